// ===== rtl/core/look_at_view_matrix_assert.svh =====
// Assertion macros shared by the look-at view matrix RTL.
`ifndef LOOK_AT_VIEW_MATRIX_ASSERT_SVH
`define LOOK_AT_VIEW_MATRIX_ASSERT_SVH

// Implication checked on every clock edge outside of reset.
`define LAV_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("look-at view matrix check failed");

// Condition that must hold on every clock edge outside of reset.
`define LAV_ASSERT_NOW(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("look-at view matrix check failed");

`endif

// ===== rtl/core/lav_pkg.sv =====
// Types, constants and rounding functions of the look-at view matrix block.
package lav_pkg;

    localparam int LAV_CRD_W = 32;   // coordinate width
    localparam int LAV_AX_W  = 16;   // Q1.14 axis entry width
    localparam int LAV_D_W   = 33;   // target minus eye, exact
    localparam int LAV_RC_W  = 48;   // up cross forward, exact
    localparam int LAV_PR_W  = 48;   // axis times coordinate
    localparam int LAV_CU_W  = 32;   // forward cross right, exact Q2.28
    localparam int LAV_ONE   = 16384;

    typedef struct packed {
        logic signed [LAV_CRD_W-1:0] eye_x;
        logic signed [LAV_CRD_W-1:0] eye_y;
        logic signed [LAV_CRD_W-1:0] eye_z;
        logic signed [LAV_CRD_W-1:0] target_x;
        logic signed [LAV_CRD_W-1:0] target_y;
        logic signed [LAV_CRD_W-1:0] target_z;
        logic signed [LAV_CRD_W-1:0] up_x;
        logic signed [LAV_CRD_W-1:0] up_y;
        logic signed [LAV_CRD_W-1:0] up_z;
    } t_lav_in;

    typedef struct packed {
        logic signed [LAV_AX_W-1:0]  right_x;
        logic signed [LAV_AX_W-1:0]  right_y;
        logic signed [LAV_AX_W-1:0]  right_z;
        logic signed [LAV_AX_W-1:0]  camup_x;
        logic signed [LAV_AX_W-1:0]  camup_y;
        logic signed [LAV_AX_W-1:0]  camup_z;
        logic signed [LAV_AX_W-1:0]  fwd_x;
        logic signed [LAV_AX_W-1:0]  fwd_y;
        logic signed [LAV_AX_W-1:0]  fwd_z;
        logic signed [LAV_CRD_W-1:0] trans_x;
        logic signed [LAV_CRD_W-1:0] trans_y;
        logic signed [LAV_CRD_W-1:0] trans_z;
    } t_lav_out;

    // Q2.28 to Q1.14, half away from zero, clamped to plus or minus one.
    function automatic logic signed [LAV_AX_W-1:0] round_q14(
        input logic signed [LAV_CU_W-1:0] x
    );
        logic [LAV_CU_W-1:0] mag;
        logic [LAV_CU_W-1:0] r;
        mag = x[LAV_CU_W-1] ? LAV_CU_W'(-x) : LAV_CU_W'(x);
        r   = (mag + LAV_CU_W'(1 << 13)) >> 14;
        if (r > LAV_CU_W'(LAV_ONE)) begin
            r = LAV_CU_W'(LAV_ONE);
        end
        return x[LAV_CU_W-1] ? -LAV_AX_W'(r) : LAV_AX_W'(r);
    endfunction

    // Negated dot product rounded to the coordinate format and saturated.
    function automatic logic signed [LAV_CRD_W-1:0] trans_round(
        input logic signed [LAV_PR_W-1:0] x
    );
        logic [LAV_PR_W-1:0]  mag;
        logic [LAV_PR_W-1:0]  r;
        logic [LAV_CRD_W-1:0] res;
        mag = x[LAV_PR_W-1] ? LAV_PR_W'(-x) : LAV_PR_W'(x);
        r   = (mag + LAV_PR_W'(1 << 13)) >> 14;
        if (x[LAV_PR_W-1]) begin
            if (r > LAV_PR_W'(32'h7FFF_FFFF)) begin
                res = 32'h7FFF_FFFF;
            end else begin
                res = LAV_CRD_W'(r);
            end
        end else begin
            if (r > LAV_PR_W'(33'h1_0000_0000 >> 1)) begin
                res = 32'h8000_0000;
            end else begin
                res = -LAV_CRD_W'(r);
            end
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/lav_stream_if.sv =====
// Valid/ready stream channel that carries one word per handshake.
interface lav_stream_if #(
    parameter type t_data = logic
);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/look_at_view_matrix.sv =====
// Look-at view matrix: takes one eye/target/up word per cycle and returns the
// unit right, camera up and forward axes in Q1.14 with the saturated
// translation in the coordinate format. The pipeline accepts a new word every
// clock cycle while the skid entry is empty; its depth is set by the two
// normalizers, each with a 32-stage square root and a 15-stage divider.
// A two-entry output buffer keeps the input side open while a finished word
// waits, and the whole pipeline freezes while the skid entry is full.
`include "look_at_view_matrix_assert.svh"

module look_at_view_matrix import lav_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    lav_stream_if.sink         i_in,
    lav_stream_if.source       o_out
);

    localparam int SIDE1_W = 6 * LAV_CRD_W;
    localparam int SIDE2_W = 3 * LAV_CRD_W + 3 * LAV_AX_W;

    logic pipe_en;

    // Entry stage.
    logic                        r_p0_vld;
    logic signed [LAV_CRD_W-1:0] r_p0_eye [3];
    logic signed [LAV_CRD_W-1:0] r_p0_up  [3];
    logic signed [LAV_D_W-1:0]   r_p0_d   [3];

    // First normalizer (forward axis).
    logic                        n1_vld;
    logic signed [LAV_AX_W-1:0]  n1_q [3];
    logic [SIDE1_W-1:0]          n1_side;
    logic signed [LAV_CRD_W-1:0] n1_eye [3];
    logic signed [LAV_CRD_W-1:0] n1_up  [3];

    // Up cross forward.
    logic                        r_x1_vld;
    logic signed [LAV_RC_W-1:0]  r_x1_p   [6];
    logic signed [LAV_CRD_W-1:0] r_x1_eye [3];
    logic signed [LAV_AX_W-1:0]  r_x1_fwd [3];
    logic                        r_x2_vld;
    logic signed [LAV_RC_W-1:0]  r_x2_rc  [3];
    logic signed [LAV_CRD_W-1:0] r_x2_eye [3];
    logic signed [LAV_AX_W-1:0]  r_x2_fwd [3];

    // Second normalizer (right axis).
    logic                        n2_vld;
    logic signed [LAV_AX_W-1:0]  n2_q [3];
    logic [SIDE2_W-1:0]          n2_side;
    logic signed [LAV_CRD_W-1:0] n2_eye [3];
    logic signed [LAV_AX_W-1:0]  n2_fwd [3];

    // Camera up and translation.
    logic                        r_t1_vld;
    logic signed [LAV_CU_W-1:0]  r_t1_cp  [6];
    logic signed [LAV_PR_W-1:0]  r_t1_re  [3];
    logic signed [LAV_PR_W-1:0]  r_t1_fe  [3];
    logic signed [LAV_CRD_W-1:0] r_t1_eye [3];
    logic signed [LAV_AX_W-1:0]  r_t1_rgt [3];
    logic signed [LAV_AX_W-1:0]  r_t1_fwd [3];
    logic                        r_t2_vld;
    logic signed [LAV_CU_W-1:0]  r_t2_cu  [3];
    logic signed [LAV_PR_W-1:0]  r_t2_sr;
    logic signed [LAV_PR_W-1:0]  r_t2_sf;
    logic signed [LAV_CRD_W-1:0] r_t2_eye [3];
    logic signed [LAV_AX_W-1:0]  r_t2_rgt [3];
    logic signed [LAV_AX_W-1:0]  r_t2_fwd [3];
    logic                        r_t3_vld;
    t_lav_out                    r_t3_res;
    logic signed [LAV_CRD_W-1:0] r_t3_eye [3];
    logic                        r_t4_vld;
    t_lav_out                    r_t4_res;
    logic signed [LAV_PR_W-1:0]  r_t4_ce  [3];
    logic                        r_t5_vld;
    t_lav_out                    r_t5_res;
    logic signed [LAV_PR_W-1:0]  r_t5_sc;
    logic                        r_t6_vld;
    t_lav_out                    r_t6_res;

    // Output register and skid entry.
    logic                        r_out_vld;
    t_lav_out                    r_out;
    logic                        r_skid_vld;
    t_lav_out                    r_skid;
    logic                        push;
    logic                        pop;

    assign pipe_en    = !r_skid_vld;
    assign i_in.ready = pipe_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_vld <= 1'b0;
            r_x1_vld <= 1'b0;
            r_x2_vld <= 1'b0;
            r_t1_vld <= 1'b0;
            r_t2_vld <= 1'b0;
            r_t3_vld <= 1'b0;
            r_t4_vld <= 1'b0;
            r_t5_vld <= 1'b0;
            r_t6_vld <= 1'b0;
        end else if (pipe_en) begin
            r_p0_vld <= i_in.valid;
            r_x1_vld <= n1_vld;
            r_x2_vld <= r_x1_vld;
            r_t1_vld <= n2_vld;
            r_t2_vld <= r_t1_vld;
            r_t3_vld <= r_t2_vld;
            r_t4_vld <= r_t3_vld;
            r_t5_vld <= r_t4_vld;
            r_t6_vld <= r_t5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_p0_eye[0] <= i_in.data.eye_x;
            r_p0_eye[1] <= i_in.data.eye_y;
            r_p0_eye[2] <= i_in.data.eye_z;
            r_p0_up[0]  <= i_in.data.up_x;
            r_p0_up[1]  <= i_in.data.up_y;
            r_p0_up[2]  <= i_in.data.up_z;
            r_p0_d[0]   <= LAV_D_W'(i_in.data.target_x) - LAV_D_W'(i_in.data.eye_x);
            r_p0_d[1]   <= LAV_D_W'(i_in.data.target_y) - LAV_D_W'(i_in.data.eye_y);
            r_p0_d[2]   <= LAV_D_W'(i_in.data.target_z) - LAV_D_W'(i_in.data.eye_z);
        end
    end

    lav_norm #(
        .IN_W   (LAV_D_W),
        .SIDE_W (SIDE1_W)
    ) u_norm_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_vld   (r_p0_vld),
        .i_vec   (r_p0_d),
        .i_side  ({r_p0_eye[0], r_p0_eye[1], r_p0_eye[2],
                   r_p0_up[0], r_p0_up[1], r_p0_up[2]}),
        .o_vld   (n1_vld),
        .o_q     (n1_q),
        .o_side  (n1_side)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_eye[i] = n1_side[SIDE1_W-1-LAV_CRD_W*i -: LAV_CRD_W];
            n1_up[i]  = n1_side[SIDE1_W-1-LAV_CRD_W*(3+i) -: LAV_CRD_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_x1_p[0] <= LAV_RC_W'(n1_up[1]) * LAV_RC_W'(n1_q[2]);
            r_x1_p[1] <= LAV_RC_W'(n1_up[2]) * LAV_RC_W'(n1_q[1]);
            r_x1_p[2] <= LAV_RC_W'(n1_up[2]) * LAV_RC_W'(n1_q[0]);
            r_x1_p[3] <= LAV_RC_W'(n1_up[0]) * LAV_RC_W'(n1_q[2]);
            r_x1_p[4] <= LAV_RC_W'(n1_up[0]) * LAV_RC_W'(n1_q[1]);
            r_x1_p[5] <= LAV_RC_W'(n1_up[1]) * LAV_RC_W'(n1_q[0]);
            r_x1_eye  <= n1_eye;
            r_x1_fwd  <= n1_q;
            r_x2_rc[0] <= r_x1_p[0] - r_x1_p[1];
            r_x2_rc[1] <= r_x1_p[2] - r_x1_p[3];
            r_x2_rc[2] <= r_x1_p[4] - r_x1_p[5];
            r_x2_eye   <= r_x1_eye;
            r_x2_fwd   <= r_x1_fwd;
        end
    end

    lav_norm #(
        .IN_W   (LAV_RC_W),
        .SIDE_W (SIDE2_W)
    ) u_norm_rgt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_vld   (r_x2_vld),
        .i_vec   (r_x2_rc),
        .i_side  ({r_x2_eye[0], r_x2_eye[1], r_x2_eye[2],
                   r_x2_fwd[0], r_x2_fwd[1], r_x2_fwd[2]}),
        .o_vld   (n2_vld),
        .o_q     (n2_q),
        .o_side  (n2_side)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n2_eye[i] = n2_side[SIDE2_W-1-LAV_CRD_W*i -: LAV_CRD_W];
            n2_fwd[i] = n2_side[3*LAV_AX_W-1-LAV_AX_W*i -: LAV_AX_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            // Forward cross right.
            r_t1_cp[0] <= LAV_CU_W'(n2_fwd[1]) * LAV_CU_W'(n2_q[2]);
            r_t1_cp[1] <= LAV_CU_W'(n2_fwd[2]) * LAV_CU_W'(n2_q[1]);
            r_t1_cp[2] <= LAV_CU_W'(n2_fwd[2]) * LAV_CU_W'(n2_q[0]);
            r_t1_cp[3] <= LAV_CU_W'(n2_fwd[0]) * LAV_CU_W'(n2_q[2]);
            r_t1_cp[4] <= LAV_CU_W'(n2_fwd[0]) * LAV_CU_W'(n2_q[1]);
            r_t1_cp[5] <= LAV_CU_W'(n2_fwd[1]) * LAV_CU_W'(n2_q[0]);
            for (int i = 0; i < 3; i++) begin
                r_t1_re[i] <= LAV_PR_W'(n2_q[i]) * LAV_PR_W'(n2_eye[i]);
                r_t1_fe[i] <= LAV_PR_W'(n2_fwd[i]) * LAV_PR_W'(n2_eye[i]);
            end
            r_t1_eye <= n2_eye;
            r_t1_rgt <= n2_q;
            r_t1_fwd <= n2_fwd;

            r_t2_cu[0] <= r_t1_cp[0] - r_t1_cp[1];
            r_t2_cu[1] <= r_t1_cp[2] - r_t1_cp[3];
            r_t2_cu[2] <= r_t1_cp[4] - r_t1_cp[5];
            r_t2_sr    <= r_t1_re[0] + r_t1_re[1] + r_t1_re[2];
            r_t2_sf    <= r_t1_fe[0] + r_t1_fe[1] + r_t1_fe[2];
            r_t2_eye   <= r_t1_eye;
            r_t2_rgt   <= r_t1_rgt;
            r_t2_fwd   <= r_t1_fwd;

            r_t3_res.right_x <= r_t2_rgt[0];
            r_t3_res.right_y <= r_t2_rgt[1];
            r_t3_res.right_z <= r_t2_rgt[2];
            r_t3_res.camup_x <= round_q14(r_t2_cu[0]);
            r_t3_res.camup_y <= round_q14(r_t2_cu[1]);
            r_t3_res.camup_z <= round_q14(r_t2_cu[2]);
            r_t3_res.fwd_x   <= r_t2_fwd[0];
            r_t3_res.fwd_y   <= r_t2_fwd[1];
            r_t3_res.fwd_z   <= r_t2_fwd[2];
            r_t3_res.trans_x <= trans_round(r_t2_sr);
            r_t3_res.trans_y <= '0;
            r_t3_res.trans_z <= trans_round(r_t2_sf);
            r_t3_eye         <= r_t2_eye;

            r_t4_res   <= r_t3_res;
            r_t4_ce[0] <= LAV_PR_W'(r_t3_res.camup_x) * LAV_PR_W'(r_t3_eye[0]);
            r_t4_ce[1] <= LAV_PR_W'(r_t3_res.camup_y) * LAV_PR_W'(r_t3_eye[1]);
            r_t4_ce[2] <= LAV_PR_W'(r_t3_res.camup_z) * LAV_PR_W'(r_t3_eye[2]);

            r_t5_res <= r_t4_res;
            r_t5_sc  <= r_t4_ce[0] + r_t4_ce[1] + r_t4_ce[2];

            r_t6_res <= {r_t5_res[$bits(t_lav_out)-1:2*LAV_CRD_W],
                         trans_round(r_t5_sc), r_t5_res.trans_z};
        end
    end

    // A word leaves the pipeline when it advances; it goes to the output
    // register if that is free this cycle, otherwise into the skid entry.
    assign push = pipe_en && r_t6_vld;
    assign pop  = r_out_vld && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (pop) begin
                r_skid_vld <= 1'b0;
            end
        end else if (push) begin
            if (!r_out_vld || pop) begin
                r_out_vld <= 1'b1;
            end else begin
                r_skid_vld <= 1'b1;
            end
        end else if (pop) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (push) begin
            if (!r_out_vld || pop) begin
                r_out <= r_t6_res;
            end else begin
                r_skid <= r_t6_res;
            end
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

    `LAV_ASSERT_NOW(a_skid_needs_out, !r_skid_vld || r_out_vld)
    `LAV_ASSERT_IMP(a_skid_fill, $rose(r_skid_vld), $past(r_out_vld && !o_out.ready))
    `LAV_ASSERT_IMP(a_skid_drain, $fell(r_skid_vld), r_out_vld && $past(o_out.ready))

endmodule

// ===== rtl/core/lav_norm.sv =====
// Pipelined normalizer: block shift, sum of squares, square root, division.
`include "look_at_view_matrix_assert.svh"

module lav_norm import lav_pkg::*; #(
    parameter int IN_W   = 33,
    parameter int SIDE_W = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_vld,
    input  logic signed [IN_W-1:0]     i_vec [3],
    input  logic        [SIDE_W-1:0]   i_side,
    output logic                       o_vld,
    output logic signed [LAV_AX_W-1:0] o_q [3],
    output logic        [SIDE_W-1:0]   o_side
);

    localparam int M_W    = 31;
    localparam int SUM_W  = 64;
    localparam int ROOT_W = 32;
    localparam int REM_W  = 35;
    localparam int NUM_W  = 46;
    localparam int Q_W    = 15;
    localparam int NCH    = (IN_W + 15) / 16;
    localparam int PW     = $clog2(NCH * 16);

    localparam int S_MAG  = 0;
    localparam int S_MAX  = 1;
    localparam int S_CHK  = 2;
    localparam int S_POS  = 3;
    localparam int S_SHF  = 4;
    localparam int S_SQR  = 5;
    localparam int S_SUM  = 6;
    localparam int SQ_N   = ROOT_W;
    localparam int S_ROOT = S_SUM + SQ_N;
    localparam int S_NUM  = S_ROOT + 1;
    localparam int DIV_N  = Q_W;
    localparam int S_QUO  = S_NUM + DIV_N;
    localparam int S_OUT  = S_QUO + 1;
    localparam int LAT    = S_OUT + 1;

    logic                   r_vld  [LAT];
    logic [SIDE_W-1:0]      r_side [LAT];
    logic [2:0]             r_neg  [LAT];
    logic                   r_zero [LAT];

    logic [IN_W-1:0]        r_mag  [S_MAG:S_POS][3];
    logic [IN_W-1:0]        r_max;
    logic [NCH-1:0]         r_nz;
    logic [3:0]             r_lpos [NCH];
    logic [PW-1:0]          r_pos;
    logic [M_W-1:0]         r_m    [S_SHF:S_ROOT][3];
    logic [2*M_W-1:0]       r_sq   [3];
    logic [SUM_W-1:0]       r_sx   [S_SUM:S_ROOT];
    logic [REM_W-1:0]       r_srem [S_SUM:S_ROOT];
    logic [ROOT_W-1:0]      r_root [S_SUM:S_ROOT];
    logic [ROOT_W-1:0]      r_len  [S_NUM:S_QUO];
    logic [NUM_W-1:0]       r_drem [S_NUM:S_QUO][3];
    logic [Q_W-1:0]         r_q    [S_NUM:S_QUO][3];
    logic signed [LAV_AX_W-1:0] r_q_out [3];

    logic [IN_W-1:0]        n_mag [3];
    logic [2:0]             n_neg;
    logic                   n_zero;

    // Entry stage: magnitudes and signs.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_neg[i] = i_vec[i][IN_W-1];
            n_mag[i] = i_vec[i][IN_W-1] ? IN_W'(-i_vec[i]) : IN_W'(i_vec[i]);
        end
        n_zero = (i_vec[0] == '0) && (i_vec[1] == '0) && (i_vec[2] == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0]     <= i_side;
            r_neg[0]      <= n_neg;
            r_zero[0]     <= n_zero;
            r_mag[S_MAG]  <= n_mag;
        end
    end

    for (genvar k = 1; k < LAT; k++) begin : g_line
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k] <= r_side[k-1];
                r_neg[k]  <= r_neg[k-1];
                r_zero[k] <= r_zero[k-1];
            end
        end
    end

    for (genvar k = S_MAG + 1; k <= S_POS; k++) begin : g_mag
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_mag[k] <= r_mag[k-1];
            end
        end
    end

    // Largest magnitude.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_mag[S_MAG][0] >= r_mag[S_MAG][1] && r_mag[S_MAG][0] >= r_mag[S_MAG][2]) begin
                r_max <= r_mag[S_MAG][0];
            end else if (r_mag[S_MAG][1] >= r_mag[S_MAG][2]) begin
                r_max <= r_mag[S_MAG][1];
            end else begin
                r_max <= r_mag[S_MAG][2];
            end
        end
    end

    // Leading one, first within 16-bit chunks, then across chunks.
    logic [NCH*16-1:0] max_pad;
    logic [NCH-1:0]    n_nz;
    logic [3:0]        n_lpos [NCH];
    logic [PW-1:0]     n_pos;

    always_comb begin
        max_pad = (NCH * 16)'(r_max);
        for (int c = 0; c < NCH; c++) begin
            n_nz[c]   = max_pad[c*16 +: 16] != 16'h0;
            n_lpos[c] = 4'h0;
            for (int b = 0; b < 16; b++) begin
                if (max_pad[c*16 + b]) begin
                    n_lpos[c] = 4'(b);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nz   <= n_nz;
            r_lpos <= n_lpos;
        end
    end

    always_comb begin
        n_pos = '0;
        for (int c = 0; c < NCH; c++) begin
            if (r_nz[c]) begin
                n_pos = PW'(c * 16) + PW'(r_lpos[c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pos <= n_pos;
        end
    end

    // One shift amount puts the largest magnitude's top bit at bit 30.
    logic [IN_W+29:0] shf_wide [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            shf_wide[i] = {r_mag[S_POS][i], 30'b0} >> r_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_m[S_SHF][i] <= shf_wide[i][M_W-1:0];
            end
        end
    end

    for (genvar k = S_SHF + 1; k <= S_ROOT; k++) begin : g_m
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[k] <= r_m[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= (2*M_W)'(r_m[S_SHF][i]) * (2*M_W)'(r_m[S_SHF][i]);
            end
            r_sx[S_SUM]   <= SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
            r_srem[S_SUM] <= '0;
            r_root[S_SUM] <= '0;
        end
    end

    // Square root, one result bit per stage.
    for (genvar k = S_SUM + 1; k <= S_ROOT; k++) begin : g_sqrt
        logic [REM_W-1:0] rem2;
        logic [REM_W-1:0] trial;

        always_comb begin
            rem2  = {r_srem[k-1][REM_W-3:0], r_sx[k-1][SUM_W-1:SUM_W-2]};
            trial = REM_W'({r_root[k-1], 2'b01});
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sx[k] <= r_sx[k-1] << 2;
                if (rem2 >= trial) begin
                    r_srem[k] <= rem2 - trial;
                    r_root[k] <= {r_root[k-1][ROOT_W-2:0], 1'b1};
                end else begin
                    r_srem[k] <= rem2;
                    r_root[k] <= {r_root[k-1][ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_len[S_NUM] <= r_root[S_ROOT];
            for (int i = 0; i < 3; i++) begin
                r_drem[S_NUM][i] <= (NUM_W'(r_m[S_ROOT][i]) << 14)
                                    + NUM_W'(r_root[S_ROOT] >> 1);
                r_q[S_NUM][i]    <= '0;
            end
        end
    end

    // Restoring division, one quotient bit per stage for all three lanes.
    for (genvar k = 1; k <= DIV_N; k++) begin : g_div
        localparam int B = DIV_N - k;
        logic [NUM_W:0] dvs;

        always_comb begin
            dvs = (NUM_W + 1)'(r_len[S_NUM+k-1]) << B;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_len[S_NUM+k] <= r_len[S_NUM+k-1];
                for (int i = 0; i < 3; i++) begin
                    if ({1'b0, r_drem[S_NUM+k-1][i]} >= dvs) begin
                        r_drem[S_NUM+k][i] <= r_drem[S_NUM+k-1][i] - dvs[NUM_W-1:0];
                        r_q[S_NUM+k][i]    <= r_q[S_NUM+k-1][i] | (Q_W'(1) << B);
                    end else begin
                        r_drem[S_NUM+k][i] <= r_drem[S_NUM+k-1][i];
                        r_q[S_NUM+k][i]    <= r_q[S_NUM+k-1][i];
                    end
                end
            end
        end
    end

    logic [Q_W-1:0] quo_clip [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            quo_clip[i] = (r_q[S_QUO][i] > Q_W'(LAV_ONE)) ? Q_W'(LAV_ONE) : r_q[S_QUO][i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                if (r_zero[S_QUO]) begin
                    r_q_out[i] <= '0;
                end else if (r_neg[S_QUO][i]) begin
                    r_q_out[i] <= -LAV_AX_W'(quo_clip[i]);
                end else begin
                    r_q_out[i] <= LAV_AX_W'(quo_clip[i]);
                end
            end
        end
    end

    assign o_vld  = r_vld[S_OUT];
    assign o_q    = r_q_out;
    assign o_side = r_side[S_OUT];

    `LAV_ASSERT_IMP(a_norm_top_bit, r_vld[S_SHF] && !r_zero[S_SHF], (r_m[S_SHF][0] | r_m[S_SHF][1] | r_m[S_SHF][2]) >= (M_W'(1) << (M_W - 1)))
    `LAV_ASSERT_IMP(a_norm_len_range, r_vld[S_NUM] && !r_zero[S_NUM], r_len[S_NUM][ROOT_W-1:ROOT_W-2] != 2'b00)
    `LAV_ASSERT_IMP(a_norm_quo_range, r_vld[S_QUO] && !r_zero[S_QUO], (r_q[S_QUO][0] <= Q_W'(LAV_ONE)) && (r_q[S_QUO][1] <= Q_W'(LAV_ONE)) && (r_q[S_QUO][2] <= Q_W'(LAV_ONE)))

endmodule

// ===== dv/lav_view_checker.sv =====
// Checker that predicts and compares look-at view matrix results.
module lav_view_checker import lav_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_ready,
    input  t_lav_in  i_in_data,
    input  logic     i_out_valid,
    input  logic     i_out_ready,
    input  t_lav_out i_out_data,
    output int       o_errors,
    output int       o_pending,
    output int       o_matrices
);

    t_lav_out view_q[$];

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Scales the largest magnitude into [2^30, 2^31) before taking the length.
    task automatic unit_vec(input logic signed [63:0] v[3], output logic signed [63:0] q[3]);
        logic [63:0] m[3];
        logic [63:0] mx;
        logic [63:0] s;
        logic [63:0] len;
        logic [63:0] c;
        mx = 0;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = mag64(v[i]);
            if (m[i] > mx) mx = m[i];
        end
        if (mx == 0) begin
            for (int i = 0; i < 3; i++) q[i] = 0;
            return;
        end
        while (mx >= (64'd1 << 31)) begin
            mx = mx >> 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
        end
        while (mx < (64'd1 << 30)) begin
            mx = mx << 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
        end
        for (int i = 0; i < 3; i++) s = s + m[i] * m[i];
        len = floor_sqrt(s);
        for (int i = 0; i < 3; i++) begin
            c = (m[i] * 64'd16384 + (len >> 1)) / len;
            if (c > 64'd16384) c = 64'd16384;
            q[i] = v[i] < 0 ? -$signed(c) : $signed(c);
        end
    endtask

    function automatic logic signed [63:0] round14(input logic signed [63:0] x);
        logic [63:0] r;
        r = (mag64(x) + 64'd8192) >> 14;
        return x < 0 ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [31:0] neg_dot(input logic signed [63:0] a[3],
                                                    input logic signed [63:0] e[3]);
        logic signed [63:0] t;
        t = -round14(a[0] * e[0] + a[1] * e[1] + a[2] * e[2]);
        if (t > 64'sh7FFF_FFFF) t = 64'sh7FFF_FFFF;
        if (t < -64'sh8000_0000) t = -64'sh8000_0000;
        return t[31:0];
    endfunction

    function automatic logic signed [63:0] clamp_one(input logic signed [63:0] x);
        return x > 16384 ? 64'sd16384 : (x < -16384 ? -64'sd16384 : x);
    endfunction

    task automatic predict_view(input t_lav_in w, output t_lav_out r);
        logic signed [63:0] eye[3];
        logic signed [63:0] up[3];
        logic signed [63:0] d[3];
        logic signed [63:0] fw[3];
        logic signed [63:0] rc[3];
        logic signed [63:0] rt[3];
        logic signed [63:0] cu[3];
        eye = '{64'(w.eye_x), 64'(w.eye_y), 64'(w.eye_z)};
        up  = '{64'(w.up_x), 64'(w.up_y), 64'(w.up_z)};
        d   = '{64'(w.target_x) - eye[0], 64'(w.target_y) - eye[1],
                64'(w.target_z) - eye[2]};
        unit_vec(d, fw);
        rc = '{up[1] * fw[2] - up[2] * fw[1], up[2] * fw[0] - up[0] * fw[2],
               up[0] * fw[1] - up[1] * fw[0]};
        unit_vec(rc, rt);
        cu = '{clamp_one(round14(fw[1] * rt[2] - fw[2] * rt[1])),
               clamp_one(round14(fw[2] * rt[0] - fw[0] * rt[2])),
               clamp_one(round14(fw[0] * rt[1] - fw[1] * rt[0]))};
        r.right_x = rt[0][15:0];
        r.right_y = rt[1][15:0];
        r.right_z = rt[2][15:0];
        r.camup_x = cu[0][15:0];
        r.camup_y = cu[1][15:0];
        r.camup_z = cu[2][15:0];
        r.fwd_x = fw[0][15:0];
        r.fwd_y = fw[1][15:0];
        r.fwd_z = fw[2][15:0];
        r.trans_x = neg_dot(rt, eye);
        r.trans_y = neg_dot(cu, eye);
        r.trans_z = neg_dot(fw, eye);
    endtask

    always @(posedge i_clk) begin
        t_lav_out exp_w;
        if (!i_rst_n) begin
            o_errors <= 0;
            o_matrices <= 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                predict_view(i_in_data, exp_w);
                view_q.push_back(exp_w);
            end
            if (i_out_valid && i_out_ready) begin
                o_matrices <= o_matrices + 1;
                if (view_q.size() == 0) begin
                    if (o_errors < 10) $display("unexpected word %h", i_out_data);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_w = view_q.pop_front();
                    if (exp_w !== i_out_data) begin
                        if (o_errors < 10)
                            $display("mismatch: expected %h got %h", exp_w, i_out_data);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

    assign o_pending = view_q.size();

endmodule

// ===== dv/tb.sv =====
// Top of the look-at view matrix testbench: stimulus, stall control and verdict.
module tb;
    import lav_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors;
    int   pending;
    int   matrices;
    int   n_directed;
    int   n_random;

    lav_stream_if #(.t_data(t_lav_in))  in_ch();
    lav_stream_if #(.t_data(t_lav_out)) out_ch();

    look_at_view_matrix uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    lav_view_checker chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .i_in_ready  (in_ch.ready),
        .i_in_data   (in_ch.data),
        .i_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .i_out_data  (out_ch.data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_matrices  (matrices)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    // The receiver stalls for a random count of cycles before each word.
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk iff out_ch.valid);
        end
    end

    function automatic logic [31:0] coord(input int mode);
        case (mode)
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
            3: return 32'($signed($urandom_range(0, 64)) - 32);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(input t_lav_in w, input bit fast);
        int gap;
        gap = fast ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= w;
        @(posedge i_clk iff in_ch.ready);
    endtask

    initial begin
        t_lav_in w;
        bit fast;
        n_directed = 0;
        n_random = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Eye equal to target, zero up, up parallel to forward, extremes.
        w = '0;
        send_word(w, 1'b0);
        w.target_z = 32'h0001_0000;
        send_word(w, 1'b1);
        w.up_y = 32'h0001_0000;
        send_word(w, 1'b1);
        w.up_y = 0;
        w.up_z = 32'h0005_0000;
        send_word(w, 1'b0);
        w = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
        send_word(w, 1'b1);
        w = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
        send_word(w, 1'b1);
        w = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 32'h0000_0001, 0,
              0, 32'h0001_0000, 0};
        send_word(w, 1'b0);
        w = '{0, 0, 0, 32'h0000_0001, 0, 0, 0, 0, 32'h0000_0001};
        send_word(w, 1'b1);
        w = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        send_word(w, 1'b1);
        n_directed = 9;
        for (int i = 0; i < 16; i++) begin
            for (int k = 0; k < 9; k++) w[k*32 +: 32] = coord($urandom_range(0, 4));
            send_word(w, 1'b0);
            n_directed++;
        end
        in_ch.valid <= 1'b0;
        // Let the pipeline drain completely before the random part.
        @(posedge i_clk iff pending == 0);
        for (int i = 0; i < 1700; i++) begin
            fast = ((i / 100) % 3) == 1;
            for (int k = 0; k < 9; k++) w[k*32 +: 32] = coord($urandom_range(0, 9));
            if ($urandom_range(0, 15) == 0) begin
                w.target_x = w.eye_x;
                w.target_y = w.eye_y;
                w.target_z = w.eye_z;
            end else if ($urandom_range(0, 15) == 0) begin
                w.up_x = w.target_x - w.eye_x;
                w.up_y = w.target_y - w.eye_y;
                w.up_z = w.target_z - w.eye_z;
            end
            send_word(w, fast);
            n_random++;
        end
        in_ch.valid <= 1'b0;
        @(posedge i_clk iff pending == 0);
        repeat (300) @(posedge i_clk);
        $display("Sent %0d directed and %0d random views; %0d matrices compared.",
                 n_directed, n_random, matrices);
        if (errors == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("Timed out with %0d views outstanding.", pending);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/lav_pkg.sv
rtl/core/lav_stream_if.sv
rtl/core/lav_norm.sv
rtl/core/look_at_view_matrix.sv
dv/lav_view_checker.sv
dv/tb.sv
